// ----- sv/dct_pkg.sv -----
// Shared constants and codes for the dirty chunk tracker.
`timescale 1ns / 1ps
`default_nettype none
package dct_pkg;

  // Sizes of the tracked chunk space and its queues.
  localparam int CHUNKS        = 4096;
  localparam int RING_DEPTH    = 256;
  localparam int MAX_PER_FRAME = 32;

  localparam int CHUNK_W  = $clog2(CHUNKS);
  localparam int COUNT_W  = 13;
  localparam int WORDS    = (CHUNKS + 63) / 64;
  localparam int WORD_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WCNT_W   = WORD_W + 1;
  localparam int RING_W   = $clog2(RING_DEPTH);
  localparam int RES_W    = (MAX_PER_FRAME > 1) ? $clog2(MAX_PER_FRAME) : 1;
  localparam int NCNT_W   = $clog2(MAX_PER_FRAME + 1);
  localparam int STAMP_W  = 32;

  // Request opcodes.
  localparam logic [1:0] OP_MARK   = 2'd0;
  localparam logic [1:0] OP_BEGIN  = 2'd1;
  localparam logic [1:0] OP_UPLOAD = 2'd2;
  localparam logic [1:0] OP_TOUCH  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

endpackage
`default_nettype wire

// ----- sv/dct_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module dct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- sv/dirty_chunk_tracker.sv -----
// Dirty chunk tracker top level: control sequencer, state memories and result register.
`timescale 1ns / 1ps
`default_nettype none
// Tracks which chunks need uploading. Chunk flags and stamps, the pending bitmap
// and the index ring live in synchronous RAMs. After reset a clearing pass
// sweeps the chunk and bitmap RAMs; no request is taken until it ends,
// while the chunk_count register can be written at any time. Mark, touch and
// upload requests run one read-modify-write of the chunk RAM before their
// result, or skip it when the index is out of range. Begin frame first
// collects into a result buffer, reading each ring entry in normal mode, or in
// overflow mode each bitmap word and each set bit found in it. It then delivers
// the results one by one. One request is in work at a time; the result
// register lets the next request in while the last result still waits.
module dirty_chunk_tracker
  import dct_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [COUNT_W-1:0]   cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           in_opcode_i,
  input  wire logic [11:0]          in_chunk_index_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      out_entry_valid_o,
  output logic [11:0]               out_dirty_index_o,
  output logic [STAMP_W-1:0]        out_dirty_stamp_o,
  output logic                      out_last_o,
  output logic [1:0]                out_status_o,
  output logic                      out_overflow_active_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MARK_RD, S_REPLY,
    S_RING_CHK, S_RING_WAIT, S_RING_EVAL,
    S_SCAN_RD, S_SCAN_LD, S_SCAN_FIND, S_SCAN_EVAL,
    S_EMIT, S_EMIT_OUT
  } state_e;

  state_e               state_q;
  logic [CHUNK_W-1:0]   clr_q;
  logic [COUNT_W-1:0]   chunk_count_q;
  logic [STAMP_W-1:0]   frame_q;
  logic [RING_W-1:0]    head_q, tail_q;
  logic                 ovf_q;
  logic [COUNT_W-1:0]   scan_q;
  logic [1:0]           op_q;
  logic [CHUNK_W-1:0]   idx_q;
  logic [1:0]           status_q;
  logic [NCNT_W-1:0]    n_q;
  logic [NCNT_W-1:0]    rd_q;
  logic [WCNT_W-1:0]    word_q;
  logic [63:0]          bits_q;
  logic [CHUNK_W-1:0]   c_q;

  // RAM ports.
  logic                     ck_we;
  logic [CHUNK_W-1:0]       ck_waddr, ck_raddr;
  logic [STAMP_W:0]         ck_wdata, ck_rdata;
  logic                     bm_we;
  logic [WORD_W-1:0]        bm_waddr, bm_raddr;
  logic [63:0]              bm_wdata, bm_rdata;
  logic                     rg_we;
  logic [RING_W-1:0]        rg_raddr;
  logic [CHUNK_W-1:0]       rg_rdata;
  logic                     rs_we;
  logic [CHUNK_W+STAMP_W-1:0] rs_wdata, rs_rdata;

  logic                 slot_free;
  logic                 out_load;
  logic                 in_acc;
  logic [COUNT_W-1:0]   total;
  logic [COUNT_W:0]     words_sum;
  logic [WCNT_W-1:0]    words;
  logic [5:0]           lsb;
  logic [CHUNK_W-1:0]   cand;
  logic [RING_W-1:0]    head_next;
  logic                 ck_dirty;

  assign slot_free  = !out_valid_o || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign total      = (chunk_count_q > COUNT_W'(CHUNKS)) ? COUNT_W'(CHUNKS) : chunk_count_q;
  assign words_sum  = {1'b0, total} + (COUNT_W+1)'(63);
  assign words      = WCNT_W'(words_sum >> 6);
  assign head_next  = (head_q == RING_W'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign ck_dirty   = ck_rdata[STAMP_W];
  assign cand       = {word_q[WORD_W-1:0], lsb};

  // A new result enters the result register in these states.
  assign out_load = slot_free && ((state_q == S_REPLY) || (state_q == S_EMIT_OUT) ||
                                  ((state_q == S_EMIT) && (n_q == '0)));

  // Lowest set bit of the current bitmap word.
  always_comb begin
    lsb = '0;
    for (int b = 63; b >= 0; b--) begin
      if (bits_q[b]) begin
        lsb = 6'(b);
      end
    end
  end

  // RAM address, data and enable selection per state.
  always_comb begin
    ck_we    = 1'b0;
    ck_waddr = idx_q;
    ck_wdata = {1'b1, frame_q};
    ck_raddr = in_chunk_index_i;
    bm_we    = 1'b0;
    bm_waddr = idx_q[CHUNK_W-1:6];
    bm_wdata = bm_rdata | (64'd1 << idx_q[5:0]);
    bm_raddr = in_chunk_index_i[CHUNK_W-1:6];
    rg_we    = 1'b0;
    rg_raddr = tail_q;
    rs_we    = 1'b0;
    rs_wdata = {c_q, ck_rdata[STAMP_W-1:0]};
    unique case (state_q)
      S_CLEAR: begin
        ck_we    = 1'b1;
        ck_waddr = clr_q;
        ck_wdata = '0;
        bm_we    = ({1'b0, clr_q} < (CHUNK_W+1)'(WORDS));
        bm_waddr = clr_q[WORD_W-1:0];
        bm_wdata = '0;
      end
      S_MARK_RD: begin
        if (op_q == OP_UPLOAD) begin
          ck_we    = ck_dirty;
          ck_wdata = {1'b0, ck_rdata[STAMP_W-1:0]};
        end else begin
          ck_we = (op_q == OP_TOUCH) || !ck_dirty;
          bm_we = ck_we;
          rg_we = ck_we && (head_next != tail_q);
        end
      end
      S_RING_WAIT: begin
        ck_raddr = rg_rdata;
        bm_raddr = rg_rdata[CHUNK_W-1:6];
      end
      S_RING_EVAL: begin
        bm_we    = ck_dirty;
        bm_waddr = c_q[CHUNK_W-1:6];
        bm_wdata = bm_rdata & ~(64'd1 << c_q[5:0]);
        rs_we    = ck_dirty;
      end
      S_SCAN_RD: begin
        bm_raddr = word_q[WORD_W-1:0];
      end
      S_SCAN_FIND: begin
        ck_raddr = cand;
        bm_we    = (bits_q != '0) && ({1'b0, cand} < total);
        bm_waddr = word_q[WORD_W-1:0];
        bm_wdata = bits_q & ~(64'd1 << lsb);
      end
      S_SCAN_EVAL: begin
        rs_we = ck_dirty;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, architectural state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q               <= S_CLEAR;
      clr_q                 <= '0;
      chunk_count_q         <= COUNT_W'(CHUNKS);
      frame_q               <= '0;
      head_q                <= '0;
      tail_q                <= '0;
      ovf_q                 <= 1'b0;
      scan_q                <= '0;
      op_q                  <= OP_MARK;
      idx_q                 <= '0;
      status_q              <= ST_DONE;
      n_q                   <= '0;
      rd_q                  <= '0;
      word_q                <= '0;
      bits_q                <= '0;
      c_q                   <= '0;
      out_valid_o           <= 1'b0;
      out_entry_valid_o     <= 1'b0;
      out_dirty_index_o     <= '0;
      out_dirty_stamp_o     <= '0;
      out_last_o            <= 1'b0;
      out_status_o          <= ST_DONE;
      out_overflow_active_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        chunk_count_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CHUNK_W'(CHUNKS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_q     <= in_opcode_i;
            idx_q    <= in_chunk_index_i;
            status_q <= ST_DONE;
            n_q      <= '0;
            rd_q     <= '0;
            if (in_opcode_i == OP_BEGIN) begin
              frame_q <= frame_q + 1'b1;
              if (ovf_q) begin
                word_q  <= scan_q[COUNT_W-1:6];
                state_q <= S_SCAN_RD;
              end else begin
                state_q <= S_RING_CHK;
              end
            end else if ({1'b0, in_chunk_index_i} >= total) begin
              status_q <= ST_IGNORED;
              state_q  <= S_REPLY;
            end else begin
              state_q <= S_MARK_RD;
            end
          end
        end
        S_MARK_RD: begin
          state_q <= S_REPLY;
          if (op_q == OP_UPLOAD) begin
            if (!ck_dirty) begin
              status_q <= ST_IGNORED;
            end
          end else if (op_q == OP_MARK && ck_dirty) begin
            status_q <= ST_IGNORED;
          end else if (head_next == tail_q) begin
            ovf_q    <= 1'b1;
            status_q <= ST_FULL;
          end else begin
            head_q <= head_next;
          end
        end
        S_REPLY: begin
          if (slot_free) begin
            out_entry_valid_o     <= 1'b0;
            out_dirty_index_o     <= '0;
            out_dirty_stamp_o     <= '0;
            out_last_o            <= 1'b1;
            out_status_o          <= status_q;
            out_overflow_active_o <= ovf_q;
            state_q               <= S_IDLE;
          end
        end
        S_RING_CHK: begin
          if (tail_q == head_q || n_q == NCNT_W'(MAX_PER_FRAME)) begin
            state_q <= S_EMIT;
          end else begin
            tail_q  <= (tail_q == RING_W'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
            state_q <= S_RING_WAIT;
          end
        end
        S_RING_WAIT: begin
          c_q <= rg_rdata;
          if ({1'b0, rg_rdata} >= total) begin
            state_q <= S_RING_CHK;
          end else begin
            state_q <= S_RING_EVAL;
          end
        end
        S_RING_EVAL: begin
          if (ck_dirty) begin
            n_q <= n_q + 1'b1;
          end
          state_q <= S_RING_CHK;
        end
        S_SCAN_RD: begin
          if (word_q >= words) begin
            ovf_q   <= 1'b0;
            scan_q  <= '0;
            head_q  <= '0;
            tail_q  <= '0;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_SCAN_LD;
          end
        end
        S_SCAN_LD: begin
          bits_q  <= bm_rdata;
          state_q <= S_SCAN_FIND;
        end
        S_SCAN_FIND: begin
          if (bits_q == '0) begin
            word_q  <= word_q + 1'b1;
            state_q <= S_SCAN_RD;
          end else if ({1'b0, cand} >= total) begin
            ovf_q   <= 1'b0;
            scan_q  <= '0;
            head_q  <= '0;
            tail_q  <= '0;
            state_q <= S_EMIT;
          end else begin
            bits_q  <= bits_q & ~(64'd1 << lsb);
            c_q     <= cand;
            state_q <= S_SCAN_EVAL;
          end
        end
        S_SCAN_EVAL: begin
          state_q <= S_SCAN_FIND;
          if (ck_dirty) begin
            n_q <= n_q + 1'b1;
            if (n_q == NCNT_W'(MAX_PER_FRAME - 1)) begin
              scan_q  <= {1'b0, c_q} + 1'b1;
              state_q <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (n_q == '0) begin
            if (slot_free) begin
              out_entry_valid_o     <= 1'b0;
              out_dirty_index_o     <= '0;
              out_dirty_stamp_o     <= '0;
              out_last_o            <= 1'b1;
              out_status_o          <= ST_DONE;
              out_overflow_active_o <= ovf_q;
              state_q               <= S_IDLE;
            end
          end else begin
            state_q <= S_EMIT_OUT;
          end
        end
        S_EMIT_OUT: begin
          if (slot_free) begin
            out_entry_valid_o     <= 1'b1;
            out_dirty_index_o     <= rs_rdata[CHUNK_W+STAMP_W-1:STAMP_W];
            out_dirty_stamp_o     <= rs_rdata[STAMP_W-1:0];
            out_last_o            <= (rd_q + 1'b1 == n_q);
            out_status_o          <= ST_DONE;
            out_overflow_active_o <= ovf_q;
            rd_q                  <= rd_q + 1'b1;
            state_q               <= (rd_q + 1'b1 == n_q) ? S_IDLE : S_EMIT;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Per-chunk dirty flag and stamp.
  dct_ram #(.WIDTH(STAMP_W + 1), .DEPTH(CHUNKS)) u_chunk_ram (
    .clk_i   (clk_i),
    .we_i    (ck_we),
    .waddr_i (ck_waddr),
    .wdata_i (ck_wdata),
    .raddr_i (ck_raddr),
    .rdata_o (ck_rdata)
  );

  // Pending bitmap, one 64-bit word per row.
  dct_ram #(.WIDTH(64), .DEPTH(WORDS)) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  // Index ring.
  dct_ram #(.WIDTH(CHUNK_W), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (rg_we),
    .waddr_i (head_q),
    .wdata_i (idx_q),
    .raddr_i (rg_raddr),
    .rdata_o (rg_rdata)
  );

  // Collected results of one frame.
  dct_ram #(.WIDTH(CHUNK_W + STAMP_W), .DEPTH(MAX_PER_FRAME)) u_result_ram (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (n_q[RES_W-1:0]),
    .wdata_i (rs_wdata),
    .raddr_i (rd_q[RES_W-1:0]),
    .rdata_o (rs_rdata)
  );

`ifndef SYNTHESIS
  // A collected entry always reports a completed request.
  a_entry_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_entry_valid_o |-> out_status_o == ST_DONE)
    else $error("collected entry with non-done status");

  // An empty result is always the final one and carries zero payload.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_entry_valid_o |->
      out_last_o && out_dirty_index_o == '0 && out_dirty_stamp_o == '0)
    else $error("empty result malformed");

  // The frame collection never exceeds its limit.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NCNT_W'(MAX_PER_FRAME))
    else $error("collection count overrun");
`endif

endmodule
`default_nettype wire
